### rtl/omci_pkg.sv
// ----------------------------------------------------------------------------
// omci_pkg : shared types and constants of the octree Morton cell locator
// Field widths, register codes, queue entry layout and the level base helper.
// ----------------------------------------------------------------------------
package omci_pkg;

	// fixed field widths
	localparam int HALF_BITS     = 23;
	localparam int FIELD_BITS    = 23;
	localparam int LEVEL_BITS    = 4;
	localparam int INDEX_BITS    = 25;
	localparam int M_DATA_BITS   = 32;
	localparam int CFG_ADDR_BITS = 3;

	// divider operand: a shifted corner below 2*field_size
	localparam int DIV_BITS = FIELD_BITS + 1;

	// two corners of three axes each
	localparam int NCOORD = 6;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// half extent is subtracted for A.x, B.y, B.z (one bit per coordinate)
	localparam logic [NCOORD-1:0] HALF_SUB = 6'b110001;

	// configuration register codes
	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_CENTER_X   = 3'd0,
		REG_CENTER_Y   = 3'd1,
		REG_CENTER_Z   = 3'd2,
		REG_HALF_X     = 3'd3,
		REG_HALF_Y     = 3'd4,
		REG_HALF_Z     = 3'd5,
		REG_FIELD_SIZE = 3'd6,
		REG_MAX_LEVEL  = 3'd7
	} cfg_reg_t;

	// range class of one shifted corner coordinate
	typedef struct packed {
		logic below;
		logic above;
	} coord_cls_t;

	typedef coord_cls_t [NCOORD-1:0] cls_vec_t;

	// one request as it waits in the queue
	typedef struct packed {
		cls_vec_t                           cls;
		logic [NCOORD-1:0][DIV_BITS-1:0]    num;
	} q_entry_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// first index of a level: (8^level - 1) / 7, a 1 in every third bit
	function automatic logic [31:0] base_of(input logic [LEVEL_BITS-1:0] level);
		logic [31:0] b;
		b = '0;
		for (int k = 0; k < 10; k++) begin
			if (k < int'(level))
				b[3*k] = 1'b1;
		end
		return b;
	endfunction

endpackage

### rtl/omci_front.sv
// ----------------------------------------------------------------------------
// omci_front : request intake and corner classification
// Forms the six shifted corner coordinates and marks those outside the field.
// ----------------------------------------------------------------------------
module omci_front #(
	parameter int COORD_BITS = 24,
	parameter int NUM_W      = 27
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_valid,
	output logic                                  s_ready,
	input  logic [2:0][COORD_BITS-1:0]            pos,
	input  logic [2:0][COORD_BITS-1:0]            center,
	input  logic [2:0][omci_pkg::HALF_BITS-1:0]   half,
	input  logic [omci_pkg::FIELD_BITS-1:0]       fs,
	input  omci_pkg::q_status_t                   q_status,
	output logic                                  push,
	output omci_pkg::q_entry_t                    entry
);
	import omci_pkg::*;

	logic                          front_en;
	logic                          vld_s1, vld_s2;
	logic [2:0][NUM_W-1:0]         pc_s1;
	logic [2:0][NUM_W-1:0]         pc_nxt;
	logic [NCOORD-1:0][NUM_W-1:0]  num_s2;
	logic [NCOORD-1:0][NUM_W-1:0]  num_nxt;
	logic [NUM_W-1:0]              two_fs;

	// stall the front only when the queue has no room
	assign front_en = !q_status.full;
	assign s_ready  = front_en;
	assign push     = vld_s2 && front_en;
	assign two_fs   = NUM_W'({fs, 1'b0});

	// stage 1: 2*(pos + center) + field_size per axis
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			pc_nxt[a] = ((NUM_W'($signed(pos[a])) + NUM_W'($signed(center[a]))) << 1)
				+ NUM_W'(fs);
		end
	end

	// stage 2: add or subtract twice the half extent per corner
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			for (int a = 0; a < 3; a++) begin
				if (HALF_SUB[3*k+a])
					num_nxt[3*k+a] = pc_s1[a] - NUM_W'({half[a], 1'b0});
				else
					num_nxt[3*k+a] = pc_s1[a] + NUM_W'({half[a], 1'b0});
			end
		end
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (front_en) begin
			vld_s1 <= s_valid;
			vld_s2 <= vld_s1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (front_en) begin
			pc_s1  <= pc_nxt;
			num_s2 <= num_nxt;
		end
	end

	// classify: negative is below, 2*field_size or more is above
	always_comb begin
		for (int c = 0; c < NCOORD; c++) begin
			entry.num[c]       = num_s2[c][DIV_BITS-1:0];
			entry.cls[c].below = num_s2[c][NUM_W-1];
			entry.cls[c].above = !num_s2[c][NUM_W-1] && (num_s2[c] >= two_fs);
		end
	end

endmodule

### rtl/omci_queue.sv
// ----------------------------------------------------------------------------
// omci_queue : short request queue between front and back
// Small register file with head/tail pointers and a fill count.
// ----------------------------------------------------------------------------
module omci_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  omci_pkg::q_entry_t   wr_entry,
	input  logic                 pop,
	output omci_pkg::q_entry_t   rd_entry,
	output omci_pkg::q_status_t  status
);
	import omci_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	q_entry_t          entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]    count_q;

	assign status.full  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign rd_entry     = entries_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= wr_entry;
	end

endmodule

### rtl/omci_back.sv
// ----------------------------------------------------------------------------
// omci_back : cell coordinate divider, Morton interleave and index
// One quotient bit per divider stage, then clamp, interleave, climb, index.
// ----------------------------------------------------------------------------
module omci_back #(
	parameter int LEVEL_LIMIT = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  omci_pkg::q_entry_t                  rd_entry,
	input  omci_pkg::q_status_t                 q_status,
	output logic                                pop,
	input  logic [omci_pkg::DIV_BITS-1:0]       two_fs,
	input  logic [omci_pkg::LEVEL_BITS-1:0]     lvl,
	input  logic                                m_ready,
	output logic                                m_valid,
	output logic [omci_pkg::INDEX_BITS-1:0]     cell_index,
	output logic [omci_pkg::LEVEL_BITS-1:0]     cell_level,
	output logic                                clamped
);
	import omci_pkg::*;

	localparam int CODE_W = 3 * LEVEL_LIMIT;
	localparam int SUM_W  = (CODE_W + 1 > INDEX_BITS) ? CODE_W + 1 : INDEX_BITS;

	logic back_en;

	// divider stages
	logic                    vld_sd [LEVEL_LIMIT];
	logic [DIV_BITS-1:0]     rem_sd [LEVEL_LIMIT][NCOORD];
	logic [LEVEL_LIMIT-1:0]  quo_sd [LEVEL_LIMIT][NCOORD];
	cls_vec_t                cls_sd [LEVEL_LIMIT];

	logic [DIV_BITS-1:0]     div_in  [LEVEL_LIMIT][NCOORD];
	logic [LEVEL_LIMIT-1:0]  quo_in  [LEVEL_LIMIT][NCOORD];
	logic [DIV_BITS-1:0]     rem_nxt [LEVEL_LIMIT][NCOORD];
	logic [LEVEL_LIMIT-1:0]  quo_nxt [LEVEL_LIMIT][NCOORD];

	// finish stage
	logic                    vld_s1;
	logic [CODE_W-1:0]       code_a_s1, code_b_s1;
	logic                    clamp_s1;
	logic [LEVEL_LIMIT-1:0]  coord [NCOORD];
	logic [CODE_W-1:0]       code_a_nxt, code_b_nxt;
	logic [LEVEL_BITS-1:0]   shift;
	logic [LEVEL_LIMIT-1:0]  top;

	// output stage
	logic                    m_valid_q;
	logic [INDEX_BITS-1:0]   cell_index_q;
	logic [LEVEL_BITS-1:0]   cell_level_q;
	logic                    clamped_q;
	logic [CODE_W-1:0]       diff;
	logic [LEVEL_BITS-1:0]   climb;
	logic [LEVEL_BITS-1:0]   level_nxt;
	logic [5:0]              code_sh;
	logic [SUM_W-1:0]        index_sum;

	// whole back end advances unless a result is waiting
	assign back_en = !m_valid_q || m_ready;
	assign pop     = back_en && !q_status.empty;

	// one restoring step: shift remainder, compare with divisor, subtract
	function automatic logic [DIV_BITS:0] div_step(input logic [DIV_BITS-1:0] r,
		input logic [DIV_BITS-1:0] d);
		logic [DIV_BITS:0] t;
		logic              ge;
		logic [DIV_BITS:0] n;
		t  = {r, 1'b0};
		ge = (t >= {1'b0, d});
		n  = ge ? (t - {1'b0, d}) : t;
		return {ge, n[DIV_BITS-1:0]};
	endfunction

	// divider stage inputs and steps
	always_comb begin
		logic [DIV_BITS:0] step;
		for (int c = 0; c < NCOORD; c++) begin
			div_in[0][c] = rd_entry.num[c];
			quo_in[0][c] = '0;
		end
		for (int j = 1; j < LEVEL_LIMIT; j++) begin
			for (int c = 0; c < NCOORD; c++) begin
				div_in[j][c] = rem_sd[j-1][c];
				quo_in[j][c] = quo_sd[j-1][c];
			end
		end
		for (int j = 0; j < LEVEL_LIMIT; j++) begin
			for (int c = 0; c < NCOORD; c++) begin
				step          = div_step(div_in[j][c], two_fs);
				rem_nxt[j][c] = step[DIV_BITS-1:0];
				quo_nxt[j][c] = LEVEL_LIMIT'({quo_in[j][c], step[DIV_BITS]});
			end
		end
	end

	// clamp, rescale to the active level and interleave
	always_comb begin
		shift      = LEVEL_BITS'(LEVEL_LIMIT) - lvl;
		top        = ~({LEVEL_LIMIT{1'b1}} << lvl);
		code_a_nxt = '0;
		code_b_nxt = '0;
		for (int c = 0; c < NCOORD; c++) begin
			if (cls_sd[LEVEL_LIMIT-1][c].above)
				coord[c] = top;
			else if (cls_sd[LEVEL_LIMIT-1][c].below)
				coord[c] = '0;
			else
				coord[c] = quo_sd[LEVEL_LIMIT-1][c] >> shift;
		end
		for (int b = 0; b < LEVEL_LIMIT; b++) begin
			for (int a = 0; a < 3; a++) begin
				code_a_nxt[3*b+a] = coord[a][b];
				code_b_nxt[3*b+a] = coord[3+a][b];
			end
		end
	end

	// highest differing group, enclosing level and linear index
	always_comb begin
		diff  = code_a_s1 ^ code_b_s1;
		climb = '0;
		for (int g = 0; g < LEVEL_LIMIT; g++) begin
			if (|diff[3*g +: 3])
				climb = LEVEL_BITS'(g + 1);
		end
		if (climb > lvl)
			climb = lvl;
		level_nxt = lvl - climb;
		code_sh   = 6'(climb) * 6'd3;
		index_sum = SUM_W'(code_a_s1 >> code_sh) + SUM_W'(base_of(level_nxt));
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < LEVEL_LIMIT; j++)
				vld_sd[j] <= 1'b0;
			vld_s1    <= 1'b0;
			m_valid_q <= 1'b0;
		end else if (back_en) begin
			vld_sd[0] <= pop;
			for (int j = 1; j < LEVEL_LIMIT; j++)
				vld_sd[j] <= vld_sd[j-1];
			vld_s1    <= vld_sd[LEVEL_LIMIT-1];
			m_valid_q <= vld_s1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (back_en) begin
			for (int j = 0; j < LEVEL_LIMIT; j++) begin
				for (int c = 0; c < NCOORD; c++) begin
					rem_sd[j][c] <= rem_nxt[j][c];
					quo_sd[j][c] <= quo_nxt[j][c];
				end
			end
			cls_sd[0] <= rd_entry.cls;
			for (int j = 1; j < LEVEL_LIMIT; j++)
				cls_sd[j] <= cls_sd[j-1];
			code_a_s1    <= code_a_nxt;
			code_b_s1    <= code_b_nxt;
			clamp_s1     <= |cls_sd[LEVEL_LIMIT-1];
			cell_index_q <= index_sum[INDEX_BITS-1:0];
			cell_level_q <= level_nxt;
			clamped_q    <= clamp_s1;
		end
	end

	assign m_valid    = m_valid_q;
	assign cell_index = cell_index_q;
	assign cell_level = cell_level_q;
	assign clamped    = clamped_q;

endmodule

### rtl/octree_morton_cell_index_top.sv
// ----------------------------------------------------------------------------
// octree_morton_cell_index_top : linear octree cell locator for a box
// Maps a box around an object position to its enclosing octree cell.
// ----------------------------------------------------------------------------
// Usage:
//  s_* channel: one request per accepted beat, s_tdata = {pos_z, pos_y, pos_x}.
//  m_* channel: one result per request, in order; m_tdata = {cell_level,
//   cell_index}, m_tuser = clamped.
//  cfg_*: write-only registers (centers, half extents, field size, max level),
//   to be written by the user only while no request is in flight; the block does not enforce this.
//  Path: the front stages, the queue, then the divider, which yields one
//   quotient bit per stage, then the finish and output stages.
//  Throughput: one request per cycle while the queue has room; every stage is pipelined.
//  Reset: registers return to their defaults (field size 512000, level 2),
//   the queue and all pipelines empty; no clearing pass.
//  Stall: a held result freezes the back end; the front keeps taking requests
//   until the 4-entry queue fills, then drops s_tready.
// ----------------------------------------------------------------------------
module octree_morton_cell_index_top #(
	parameter int LEVEL_LIMIT = 8,
	parameter int COORD_BITS  = 24
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	// request stream
	input  logic                                        s_tvalid,
	output logic                                        s_tready,
	// pos_x, pos_y, pos_z (from bit 0)
	input  logic [((3*COORD_BITS+7)/8)*8-1:0]           s_tdata,
	// result stream
	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	// cell_index, cell_level (from bit 0)
	output logic [omci_pkg::M_DATA_BITS-1:0]            m_tdata,
	// clamped
	output logic                                        m_tuser,
	// configuration writes
	input  logic                                        cfg_we,
	input  logic [omci_pkg::CFG_ADDR_BITS-1:0]          cfg_addr,
	input  logic [((COORD_BITS > omci_pkg::FIELD_BITS) ? COORD_BITS
		: omci_pkg::FIELD_BITS)-1:0]                    cfg_data
);
	import omci_pkg::*;

	localparam int NUM_W = ((COORD_BITS > HALF_BITS + 1) ? COORD_BITS : HALF_BITS + 1) + 3;
	localparam int PAD_W = M_DATA_BITS - LEVEL_BITS - INDEX_BITS;

	// configuration registers
	logic [2:0][COORD_BITS-1:0]  center_q;
	logic [2:0][HALF_BITS-1:0]   half_q;
	logic [FIELD_BITS-1:0]       field_size_q;
	logic [LEVEL_BITS-1:0]       max_level_q;

	logic [FIELD_BITS-1:0]       fs_eff;
	logic [LEVEL_BITS-1:0]       lvl_eff;
	logic [DIV_BITS-1:0]         two_fs;
	logic [2:0][COORD_BITS-1:0]  pos;

	logic                        push, pop;
	q_entry_t                    wr_entry, rd_entry;
	q_status_t                   q_status;

	logic [INDEX_BITS-1:0]       cell_index;
	logic [LEVEL_BITS-1:0]       cell_level;
	logic                        clamped;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q     <= '0;
			half_q       <= '0;
			field_size_q <= FIELD_BITS'(512000);
			max_level_q  <= LEVEL_BITS'(2);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_CENTER_X:   center_q[0]  <= cfg_data[COORD_BITS-1:0];
				REG_CENTER_Y:   center_q[1]  <= cfg_data[COORD_BITS-1:0];
				REG_CENTER_Z:   center_q[2]  <= cfg_data[COORD_BITS-1:0];
				REG_HALF_X:     half_q[0]    <= cfg_data[HALF_BITS-1:0];
				REG_HALF_Y:     half_q[1]    <= cfg_data[HALF_BITS-1:0];
				REG_HALF_Z:     half_q[2]    <= cfg_data[HALF_BITS-1:0];
				REG_FIELD_SIZE: field_size_q <= cfg_data[FIELD_BITS-1:0];
				REG_MAX_LEVEL:  max_level_q  <= cfg_data[LEVEL_BITS-1:0];
				default:        max_level_q  <= max_level_q;
			endcase
		end
	end

	// effective field size and level
	assign fs_eff  = (field_size_q == '0) ? FIELD_BITS'(1) : field_size_q;
	assign lvl_eff = (max_level_q > LEVEL_BITS'(LEVEL_LIMIT)) ? LEVEL_BITS'(LEVEL_LIMIT)
		: max_level_q;
	assign two_fs  = {fs_eff, 1'b0};

	// unpack request
	always_comb begin
		for (int a = 0; a < 3; a++)
			pos[a] = s_tdata[a*COORD_BITS +: COORD_BITS];
	end

	omci_front #(
		.COORD_BITS (COORD_BITS),
		.NUM_W      (NUM_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_valid  (s_tvalid),
		.s_ready  (s_tready),
		.pos      (pos),
		.center   (center_q),
		.half     (half_q),
		.fs       (fs_eff),
		.q_status (q_status),
		.push     (push),
		.entry    (wr_entry)
	);

	omci_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.status   (q_status)
	);

	omci_back #(
		.LEVEL_LIMIT (LEVEL_LIMIT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_entry   (rd_entry),
		.q_status   (q_status),
		.pop        (pop),
		.two_fs     (two_fs),
		.lvl        (lvl_eff),
		.m_ready    (m_tready),
		.m_valid    (m_tvalid),
		.cell_index (cell_index),
		.cell_level (cell_level),
		.clamped    (clamped)
	);

	// pack result
	assign m_tdata = {{PAD_W{1'b0}}, cell_level, cell_index};
	assign m_tuser = clamped;

	// result level never deeper than the active level
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (cell_level <= lvl_eff))
		else $error("cell level beyond active level");

	// index falls inside the block of its own level (checked only for LEVEL_LIMIT <= 8)
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((LEVEL_LIMIT > 8)
			|| ((32'(cell_index) >= base_of(cell_level))
			&& (32'(cell_index) < base_of(cell_level + 4'd1)))))
		else $error("cell index outside its level");

endmodule
